[sv/ppt_pkg.sv]
`default_nettype none
package ppt_pkg;

  localparam int unsigned Capacity     = 64;
  localparam int unsigned PayloadBits  = 32;
  localparam int unsigned PriorityBits = 16;
  localparam int unsigned IdBits       = $clog2(Capacity);
  localparam int unsigned CountBits    = $clog2(Capacity + 1);

  localparam logic [2:0] KindAdd     = 3'd0;
  localparam logic [2:0] KindPromote = 3'd1;
  localparam logic [2:0] KindPeek    = 3'd2;
  localparam logic [2:0] KindPop     = 3'd3;
  localparam logic [2:0] KindQuery   = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StNotLive = 2'd2;
  localparam logic [1:0] StEmpty   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  item_id;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  out_id;
    logic [31:0] out_payload;
    logic [15:0] out_priority;
    logic        id_valid;
  } rsp_t;

  // Candidate that travels down the chain during a search.
  typedef struct packed {
    logic                    found;
    logic [IdBits-1:0]       id;
    logic [PriorityBits-1:0] prio;
    logic [PayloadBits-1:0]  payload;
  } cand_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                   wr;
    logic                   inc;
    logic                   kill;
    logic [IdBits-1:0]      id;
    logic [PayloadBits-1:0] payload;
  } cell_cmd_t;

endpackage
`default_nettype wire

[sv/ppt_cell.sv]
`default_nettype none
module ppt_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ppt_pkg::IdBits-1:0] my_id_i,
  input  wire ppt_pkg::cell_cmd_t cmd_i,
  input  wire ppt_pkg::cand_t     cand_i,
  output ppt_pkg::cand_t          cand_o,
  output ppt_pkg::cand_t          self_o
);
  import ppt_pkg::*;

  logic                    live_q;
  logic [PriorityBits-1:0] prio_q;
  logic [PayloadBits-1:0]  pay_q;
  logic                    hit;

  assign hit = (cmd_i.id == my_id_i);

  // Live flag is control state; priority and payload need no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (hit && cmd_i.wr) begin
      live_q <= 1'b1;
    end else if (hit && cmd_i.kill) begin
      live_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && cmd_i.wr) begin
      prio_q <= '0;
      pay_q  <= cmd_i.payload;
    end else if (hit && cmd_i.inc && (prio_q != '1)) begin
      prio_q <= prio_q + 1'b1;
    end
  end

  // Higher id wins ties, and ids rise along the chain.
  always_comb begin
    self_o.found   = live_q;
    self_o.id      = my_id_i;
    self_o.prio    = prio_q;
    self_o.payload = pay_q;
    if (live_q && (!cand_i.found || prio_q >= cand_i.prio)) begin
      cand_o = self_o;
    end else begin
      cand_o = cand_i;
    end
  end

endmodule
`default_nettype wire

[sv/ppt_chain.sv]
`default_nettype none
module ppt_chain (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ppt_pkg::cell_cmd_t cmd_i,
  input  wire logic [ppt_pkg::IdBits-1:0] sel_i,
  output ppt_pkg::cand_t          best_o,
  output ppt_pkg::cand_t          sel_o
);
  import ppt_pkg::*;

  localparam int unsigned Seg = 8;
  localparam int unsigned NSeg = (Capacity + Seg - 1) / Seg;

  cand_t link [Capacity];
  cand_t self [Capacity];
  cand_t seg_q [NSeg];

  // Each segment of eight cells is closed by a register; the segment
  // results are then folded combinationally into the best candidate.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    cand_t cin;
    if ((i % Seg) == 0) begin : g_head
      assign cin = '0;
    end else begin : g_body
      assign cin = link[i-1];
    end
    ppt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .my_id_i(IdBits'(i)),
      .cmd_i  (cmd_i),
      .cand_i (cin),
      .cand_o (link[i]),
      .self_o (self[i])
    );
  end

  for (genvar s = 0; s < NSeg; s++) begin : g_seg
    localparam int unsigned Last = ((s + 1) * Seg > Capacity) ? Capacity : (s + 1) * Seg;
    always_ff @(posedge clk_i) begin
      seg_q[s] <= link[Last-1];
    end
  end

  always_comb begin
    best_o = '0;
    for (int s = 0; s < NSeg; s++) begin
      if (seg_q[s].found && (!best_o.found || seg_q[s].prio >= best_o.prio)) begin
        best_o = seg_q[s];
      end
    end
  end

  assign sel_o = self[sel_i];

endmodule
`default_nettype wire

[sv/promotable_priority_table_core.sv]
`default_nettype none
// Promotable priority table.
// Request channel req_valid_i/req_ready_o carries req_i (kind, item_id,
// payload); response channel rsp_valid_o/rsp_ready_i carries rsp_o.
// Every request gives exactly one response.
// Entries live in a chain of cells, one per id. Each cell compares itself
// with the candidate from its neighbor; the chain is registered every eight
// cells and the segment winners are folded in the next cycle.
// In StScan the chain settles and is caught in the segment registers; in
// StExec the segments are folded, the request is acted on and the response
// is registered. One request is in flight at a time: the block is not
// ready for a new request until the response has been taken.
// A stalled response is held in its register; no new request is taken
// until it has gone.
// Reset clears all live flags and the id counter; the table is empty and
// ready as soon as reset is released.
module promotable_priority_table_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire ppt_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output ppt_pkg::rsp_t      rsp_o
);
  import ppt_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StExec = 2'd2;
  localparam logic [1:0] StResp = 2'd3;

  logic [1:0]           state_q, state_d;
  req_t                 req_q;
  logic [CountBits-1:0] next_q, next_d;
  rsp_t                 rsp_q, rsp_d;
  cell_cmd_t            cmd;
  cand_t                best, sel;
  logic                 id_ok, live;

  assign req_ready_o = (state_q == StIdle);
  assign rsp_valid_o = (state_q == StResp);
  assign rsp_o       = rsp_q;

  assign id_ok = (int'(req_q.item_id) < Capacity);
  assign live  = id_ok && sel.found;

  ppt_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sel_i (IdBits'(req_q.item_id)),
    .best_o(best),
    .sel_o (sel)
  );

  // Step the state machine and, in StExec, execute the request against the settled chain.
  always_comb begin
    cmd     = '0;
    rsp_d   = rsp_q;
    next_d  = next_q;
    state_d = state_q;
    cmd.payload = PayloadBits'(req_q.payload);
    cmd.id      = IdBits'(req_q.item_id);
    unique case (state_q)
      StIdle: if (req_valid_i) state_d = StScan;
      StScan: state_d = StExec;
      StExec: begin
        state_d = StResp;
        rsp_d   = '0;
        case (req_q.kind) inside
          KindAdd: begin
            if (int'(next_q) >= Capacity) begin
              rsp_d.status = StFull;
            end else begin
              cmd.wr        = 1'b1;
              cmd.id        = IdBits'(next_q);
              rsp_d.status  = StOk;
              rsp_d.out_id  = 6'(next_q);
              next_d        = next_q + 1'b1;
            end
          end
          KindPromote, KindQuery: begin
            rsp_d.out_id = req_q.item_id;
            if (!live) begin
              rsp_d.status = StNotLive;
            end else begin
              cmd.inc            = (req_q.kind == KindPromote);
              rsp_d.out_payload  = 32'(sel.payload);
              rsp_d.out_priority = 16'(((req_q.kind == KindPromote) &&
                                        (sel.prio != '1)) ? sel.prio + 1'b1 : sel.prio);
              rsp_d.id_valid     = 1'b1;
            end
          end
          KindPeek, KindPop: begin
            if (!best.found) begin
              rsp_d.status = StEmpty;
            end else begin
              cmd.kill           = (req_q.kind == KindPop);
              cmd.id             = best.id;
              rsp_d.out_id       = 6'(best.id);
              rsp_d.out_payload  = 32'(best.payload);
              rsp_d.out_priority = 16'(best.prio);
              rsp_d.id_valid     = 1'b1;
            end
          end
          default: rsp_d = '0;
        endcase
      end
      StResp: if (rsp_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      next_q  <= '0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

endmodule
`default_nettype wire

[sv/ppt_checker.sv]
`default_nettype none
module ppt_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid_i,
  input wire logic          req_ready_o,
  input wire logic          rsp_valid_o,
  input wire logic          rsp_ready_i,
  input wire ppt_pkg::rsp_t rsp_o
);
  import ppt_pkg::*;

  // A stalled response holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  // No request is taken while a response waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o))
    else $error("request accepted with response pending");

  // An accepted request yields a response.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |-> ##3 rsp_valid_o)
    else $error("response latency broken");

  // Error statuses carry no valid flag.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != StOk |-> !rsp_o.id_valid)
    else $error("error response flagged valid");

endmodule

bind promotable_priority_table_core ppt_checker u_ppt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_valid_i),
  .req_ready_o(req_ready_o),
  .rsp_valid_o(rsp_valid_o),
  .rsp_ready_i(rsp_ready_i),
  .rsp_o      (rsp_o)
);
`default_nettype wire
